// ----- design/itra_pkg.sv -----
// Shared types and constants for the integer to radix ASCII converter.
`timescale 1ns / 1ps
package itra_pkg;
    localparam logic [5:0] RADIX_MIN = 6'd2;
    localparam logic [5:0] RADIX_MAX = 6'd36;
    localparam logic [5:0] RADIX_DEC = 6'd10;
    localparam logic [6:0] CHAR_ZERO = 7'h30;
    localparam logic [6:0] CHAR_A_LOW = 7'h61;
    localparam logic [6:0] CHAR_MINUS = 7'h2d;
    localparam logic [5:0] DIGIT_NINE = 6'd9;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIVIDE,
        BK_EMIT
    } bk_state_t;

    function automatic logic [6:0] digit_to_char(input logic [5:0] d);
        logic [6:0] c;
        if (d > DIGIT_NINE)
        begin
            c = CHAR_A_LOW + {1'b0, d} - 7'd10;
        end
        else
        begin
            c = CHAR_ZERO + {1'b0, d};
        end
        return c;
    endfunction
endpackage

// ----- design/itra_front.sv -----
// Front part: accepts commands, classifies them and queues the job.
`timescale 1ns / 1ps
module itra_front
    import itra_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [5:0]            radix,
    output logic                  busy,
    output logic                  job_valid,
    output logic [VALUE_BITS-1:0] job_mag,
    output logic [5:0]            job_radix,
    output logic                  job_neg,
    output logic                  job_bad,
    input  logic                  job_take
);
    // One-entry queue between front and back.
    logic                  full_reg;
    logic [VALUE_BITS-1:0] mag_reg;
    logic [5:0]            radix_reg;
    logic                  neg_reg;
    logic                  bad_reg;
    logic                  neg_c;
    logic                  accept;

    assign busy = full_reg;
    assign accept = start && !full_reg;
    assign neg_c = (radix == RADIX_DEC) && value[VALUE_BITS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (accept)
        begin
            full_reg <= 1'b1;
        end
        else if (job_take)
        begin
            full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mag_reg   <= neg_c ? (~value + 1'b1) : value;
            radix_reg <= radix;
            neg_reg   <= neg_c;
            bad_reg   <= (radix < RADIX_MIN) || (radix > RADIX_MAX);
        end
    end

    assign job_valid = full_reg;
    assign job_mag   = mag_reg;
    assign job_radix = radix_reg;
    assign job_neg   = neg_reg;
    assign job_bad   = bad_reg;
endmodule

// ----- design/itra_back.sv -----
// Back part: bit-serial division into a digit stack, then character output.
`timescale 1ns / 1ps
module itra_back
    import itra_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  job_valid,
    input  logic [VALUE_BITS-1:0] job_mag,
    input  logic [5:0]            job_radix,
    input  logic                  job_neg,
    input  logic                  job_bad,
    output logic                  job_take,
    output logic                  done,
    output logic [6:0]            digit_char,
    output logic                  last_char,
    output logic                  bad_radix
);
    localparam int CW = $clog2(VALUE_BITS + 1);
    localparam int SW = $clog2(VALUE_BITS);

    bk_state_t state_reg, state_next;
    logic [VALUE_BITS-1:0] quo_reg;
    logic [5:0]            rem_reg;
    logic [5:0]            radix_reg;
    logic [CW-1:0]         bit_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  neg_reg;
    logic                  bad_reg;
    logic [5:0]            stack_mem [VALUE_BITS];
    logic [6:0]            trial;
    logic                  ge;
    logic                  last_bit;
    logic                  emit;

    // Restoring division step: one quotient bit a cycle.
    assign trial = {rem_reg, quo_reg[VALUE_BITS-1]};
    assign ge = trial >= {1'b0, radix_reg};
    assign last_bit = (bit_reg == CW'(VALUE_BITS - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = job_bad ? BK_EMIT : BK_DIVIDE;
                end
            end
            BK_DIVIDE:
            begin
                if (last_bit && ({quo_reg[VALUE_BITS-2:0], ge} == '0
                    || cnt_reg == CW'(VALUE_BITS - 1)))
                begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (!neg_reg && (bad_reg || cnt_reg == CW'(1)))
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        job_take = (state_reg == BK_IDLE) && job_valid;
        emit = (state_reg == BK_EMIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            cnt_reg   <= '0;
            neg_reg   <= 1'b0;
            bad_reg   <= 1'b0;
            done      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done      <= emit;
            if (job_take)
            begin
                cnt_reg <= '0;
                neg_reg <= job_neg;
                bad_reg <= job_bad;
            end
            else if (state_reg == BK_DIVIDE && last_bit)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (emit)
            begin
                if (neg_reg)
                begin
                    neg_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            quo_reg   <= job_mag;
            rem_reg   <= '0;
            bit_reg   <= '0;
            radix_reg <= job_radix;
        end
        else if (state_reg == BK_DIVIDE)
        begin
            if (last_bit)
            begin
                stack_mem[cnt_reg[SW-1:0]] <= ge ? 6'(trial - {1'b0, radix_reg})
                                                 : trial[5:0];
                rem_reg <= '0;
                bit_reg <= '0;
            end
            else
            begin
                rem_reg <= ge ? 6'(trial - {1'b0, radix_reg}) : trial[5:0];
                bit_reg <= bit_reg + 1'b1;
            end
            quo_reg <= {quo_reg[VALUE_BITS-2:0], ge};
        end
        if (emit)
        begin
            if (bad_reg)
            begin
                digit_char <= '0;
                last_char  <= 1'b1;
                bad_radix  <= 1'b1;
            end
            else if (neg_reg)
            begin
                digit_char <= CHAR_MINUS;
                last_char  <= 1'b0;
                bad_radix  <= 1'b0;
            end
            else
            begin
                digit_char <= digit_to_char(stack_mem[SW'(cnt_reg - 1'b1)]);
                last_char  <= (cnt_reg == CW'(1));
                bad_radix  <= 1'b0;
            end
        end
    end
endmodule

// ----- design/integer_to_radix_ascii.sv -----
// Top level of the integer to radix ASCII converter.
`timescale 1ns / 1ps
// A transaction is accepted when start is high and busy is low; value and
// radix are sampled then. Characters come out most significant digit first,
// each shown for exactly one cycle with done high; the receiver cannot stall
// them. Base 10 negatives lead with '-'. A bad radix gives one result with
// bad_radix set. The front stage classifies the command into a one-entry
// queue, so busy drops as soon as the back stage takes the job. The back
// stage uses a shared bit-serial divider that produces the digits least
// significant first into a digit stack, which is then read out from the top.
module integer_to_radix_ascii
    import itra_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [5:0]            radix,
    output logic                  done,
    output logic [6:0]            digit_char,
    output logic                  last_char,
    output logic                  bad_radix
);
    logic                  job_valid;
    logic [VALUE_BITS-1:0] job_mag;
    logic [5:0]            job_radix;
    logic                  job_neg;
    logic                  job_bad;
    logic                  job_take;

    itra_front #(.VALUE_BITS(VALUE_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .value(value), .radix(radix),
        .busy(busy), .job_valid(job_valid), .job_mag(job_mag),
        .job_radix(job_radix), .job_neg(job_neg), .job_bad(job_bad),
        .job_take(job_take)
    );

    itra_back #(.VALUE_BITS(VALUE_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job_mag(job_mag),
        .job_radix(job_radix), .job_neg(job_neg), .job_bad(job_bad),
        .job_take(job_take), .done(done), .digit_char(digit_char),
        .last_char(last_char), .bad_radix(bad_radix)
    );
endmodule

// ----- tb/integer_to_radix_ascii_tb.sv -----
// Self-checking testbench for the integer to radix ASCII converter.
`timescale 1ns / 1ps
module integer_to_radix_ascii_tb
    import itra_pkg::*;
;

    localparam int VALUE_BITS = 32;
    // Must cover the slowest job, a full base 2 conversion, plus a long input gap.
    localparam int STALL_LIMIT = 20000;
    localparam int N_RANDOM = 400;

    // One expected character of the output stream.
    typedef struct packed {
        logic [6:0] ch;
        logic       last;
        logic       bad;
    } char_exp_t;

    // One row of the directed table. When has_first is set, the first
    // character expected is also typed in and checked against the predictor.
    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [5:0]            radix;
        logic                  has_first;
        char_exp_t             first;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [VALUE_BITS-1:0] value;
    logic [5:0]            radix;
    logic                  done;
    logic [6:0]            digit_char;
    logic                  last_char;
    logic                  bad_radix;

    char_exp_t pending_chars[$];
    int        fail_count;
    int        idle_cycles;

    integer_to_radix_ascii #(.VALUE_BITS(VALUE_BITS)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .value(value),
        .radix(radix),
        .done(done),
        .digit_char(digit_char),
        .last_char(last_char),
        .bad_radix(bad_radix)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Predicts the character stream for one transaction and appends it to the
    // queue. Base 10 treats the value as signed; every other base converts
    // the raw bit pattern as unsigned.
    function automatic void predict_chars(input logic [VALUE_BITS-1:0] v,
                                          input logic [5:0] r);
        logic [VALUE_BITS-1:0] mag;
        logic [6:0]            digs[$];
        logic [5:0]            d;
        char_exp_t             e;
        if (r < RADIX_MIN || r > RADIX_MAX)
        begin
            e = '{ch: 7'd0, last: 1'b1, bad: 1'b1};
            pending_chars.push_back(e);
            return;
        end
        mag = v;
        if (r == RADIX_DEC && v[VALUE_BITS-1])
        begin
            mag = -v;
            e = '{ch: CHAR_MINUS, last: 1'b0, bad: 1'b0};
            pending_chars.push_back(e);
        end
        if (mag == '0)
        begin
            digs.push_front(CHAR_ZERO);
        end
        while (mag != '0)
        begin
            d = 6'(mag % r);
            digs.push_front(d > DIGIT_NINE ? CHAR_A_LOW + 7'(d) - 7'd10
                                           : CHAR_ZERO + 7'(d));
            mag = mag / r;
        end
        foreach (digs[i])
        begin
            e = '{ch: digs[i], last: (i == digs.size() - 1), bad: 1'b0};
            pending_chars.push_back(e);
        end
    endfunction

    // Output checker: each strobed character is compared with the oldest
    // expectation, field by field.
    always @(posedge clk)
    begin
        char_exp_t e;
        if (rst_n && done)
        begin
            if (pending_chars.size() == 0)
            begin
                $display("%0t: unexpected character, expected none, got %h",
                         $time, digit_char);
                fail_count++;
            end
            else
            begin
                e = pending_chars.pop_front();
                if (digit_char !== e.ch)
                begin
                    $display("%0t: digit_char mismatch, expected %h, got %h",
                             $time, e.ch, digit_char);
                    fail_count++;
                end
                if (last_char !== e.last)
                begin
                    $display("%0t: last_char mismatch, expected %b, got %b",
                             $time, e.last, last_char);
                    fail_count++;
                end
                if (bad_radix !== e.bad)
                begin
                    $display("%0t: bad_radix mismatch, expected %b, got %b",
                             $time, e.bad, bad_radix);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles where neither a command nor a character moves.
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Short gaps are common, long ones rare, and often none at all.
    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            return 0;
        end
        if (pick < 92)
        begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(20, 300);
    endfunction

    // Holds start high at the falling edge until the command is taken at a
    // rising edge, then records the expected characters. The inputs are
    // driven at the falling edge, away from the sampling edge.
    task automatic issue_command(input logic [VALUE_BITS-1:0] v,
                                 input logic [5:0] r);
        int gap;
        gap = gap_length();
        repeat (gap)
        begin
            @(negedge clk);
        end
        start = 1'b1;
        value = v;
        radix = r;
        forever
        begin
            @(posedge clk);
            if (!busy)
            begin
                break;
            end
        end
        predict_chars(v, r);
        @(negedge clk);
        start = 1'b0;
    endtask

    // Random operand with a mix of sizes so both short and long digit strings
    // appear, plus the edge patterns.
    function automatic logic [VALUE_BITS-1:0] random_value();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0: return '0;
            1: return {1'b1, {(VALUE_BITS-1){1'b0}}};
            2: return {VALUE_BITS{1'b1}};
            3: return VALUE_BITS'($urandom_range(0, 40));
            4: return -VALUE_BITS'($urandom_range(1, 40));
            5: return VALUE_BITS'($urandom_range(0, 65535));
            default: return VALUE_BITS'($urandom);
        endcase
    endfunction

    // Mostly valid bases; a few out-of-range ones for the error path.
    function automatic logic [5:0] random_radix();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
        begin
            return 6'($urandom_range(0, 1));
        end
        if (pick == 1)
        begin
            return 6'($urandom_range(37, 63));
        end
        if (pick < 6)
        begin
            return RADIX_DEC;
        end
        return 6'($urandom_range(2, 36));
    endfunction

    initial
    begin
        dir_row_t directed[$];
        dir_row_t row;
        int       wait_cycles;
        char_exp_t first_pred;

        fail_count = 0;
        start = 1'b0;
        value = '0;
        radix = RADIX_DEC;
        rst_n = 1'b0;

        // Directed rows: zero, extremes of value in several bases, every
        // base boundary, and out-of-range bases (expected result known).
        directed = '{
            '{'0, RADIX_DEC, 1'b1, '{CHAR_ZERO, 1'b1, 1'b0}},
            '{'0, 6'd2, 1'b1, '{CHAR_ZERO, 1'b1, 1'b0}},
            '{32'h8000_0000, RADIX_DEC, 1'b1, '{CHAR_MINUS, 1'b0, 1'b0}},
            '{32'hffff_ffff, RADIX_DEC, 1'b1, '{CHAR_MINUS, 1'b0, 1'b0}},
            '{32'h7fff_ffff, RADIX_DEC, 1'b0, '0},
            '{32'hffff_ffff, 6'd2, 1'b0, '0},
            '{32'hffff_ffff, 6'd16, 1'b0, '0},
            '{32'h8000_0000, 6'd16, 1'b0, '0},
            '{32'hffff_ffff, RADIX_MAX, 1'b0, '0},
            '{32'd35, RADIX_MAX, 1'b1, '{7'h7a, 1'b1, 1'b0}},
            '{32'd9, RADIX_DEC, 1'b1, '{7'h39, 1'b1, 1'b0}},
            '{32'd10, 6'd11, 1'b1, '{CHAR_A_LOW, 1'b1, 1'b0}},
            '{32'd1, 6'd2, 1'b1, '{7'h31, 1'b1, 1'b0}},
            '{32'h5555_aaaa, 6'd3, 1'b0, '0},
            '{32'haaaa_5555, 6'd7, 1'b0, '0},
            '{32'd12345, RADIX_DEC, 1'b0, '0},
            '{32'd77, 6'd0, 1'b1, '{7'd0, 1'b1, 1'b1}},
            '{32'd77, 6'd1, 1'b1, '{7'd0, 1'b1, 1'b1}},
            '{32'd77, 6'd37, 1'b1, '{7'd0, 1'b1, 1'b1}},
            '{32'hffff_ffff, 6'd63, 1'b1, '{7'd0, 1'b1, 1'b1}}
        };

        repeat (10)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            row = directed[i];
            if (row.has_first)
            begin
                // Cross-check the hand-typed first character against the
                // predictor; the queue is empty here, so its head is the
                // first character of this row.
                predict_chars(row.value, row.radix);
                first_pred = pending_chars[0];
                pending_chars.delete();
                if (first_pred != row.first)
                begin
                    $display("%0t: directed row %0d, expected %h, predicted %h",
                             $time, i, row.first, first_pred);
                    fail_count++;
                end
            end
            issue_command(row.value, row.radix);
            // Wait for the stream to drain so the table check above only
            // ever sees this row's characters.
            while (pending_chars.size() != 0)
            begin
                @(negedge clk);
            end
        end

        repeat (N_RANDOM)
        begin
            issue_command(random_value(), random_radix());
        end

        wait_cycles = 0;
        while (pending_chars.size() != 0 && wait_cycles < 4 * STALL_LIMIT)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (VALUE_BITS * (VALUE_BITS + 2))
        begin
            @(negedge clk);
        end

        if (fail_count == 0 && pending_chars.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
